// ===== rtl/jpeg_bit_writer_with_stuffing_unit_assert.svh =====
// Assertion macros shared by the bit writer RTL.
`ifndef JPEG_BIT_WRITER_WITH_STUFFING_UNIT_ASSERT_SVH
`define JPEG_BIT_WRITER_WITH_STUFFING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JBWS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JBWS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jbws_pkg.sv =====
`timescale 1ns / 1ps
package jbws_pkg;

   localparam int OP_W    = 3;
   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int SHIFT_W = 5;
   localparam int CNT_W   = 5;
   localparam int PEND_W  = 7;
   localparam int PCNT_W  = 3;
   localparam int REM_W   = 3;

   localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;

   typedef enum logic [OP_W-1:0] {
      OP_BITS   = 3'd0,
      OP_BYTE   = 3'd1,
      OP_WORD16 = 3'd2,
      OP_WORD32 = 3'd3,
      OP_MARKER = 3'd4
   } op_type;

endpackage

// ===== rtl/jbws_byte_sel.sv =====
`timescale 1ns / 1ps
// Shared byte extractor: one barrel shift, low byte out.
module jbws_byte_sel (
   input  logic [jbws_pkg::WORD_W-1:0]  word,
   input  logic [jbws_pkg::SHIFT_W-1:0] shift,
   output logic [jbws_pkg::BYTE_W-1:0]  byte_out,
   output logic                         is_ff
);
   import jbws_pkg::*;

   logic [WORD_W-1:0] shifted;

   assign shifted  = word >> shift;
   assign byte_out = shifted[BYTE_W-1:0];
   assign is_ff    = (shifted[BYTE_W-1:0] == MARKER_PREFIX);

endmodule

// ===== rtl/jpeg_bit_writer_with_stuffing_unit.sv =====
`timescale 1ns / 1ps
// JPEG entropy bit writer with 0xFF stuffing. A transaction on the req_
// channel either appends 0..MAX_CODE_BITS code bits MSB first (op 0), or
// writes one byte, a 16-bit or 32-bit word in the chosen byte order, or a
// marker (0xFF then the code). Each stream byte leaves as one rsp_
// transaction, rsp_last marking the final byte of the request. Complete
// bytes built from code bits get a 0x00 inserted after every 0xFF; raw and
// marker writes bypass the bit cache and leave up to 7 pending bits alone.
// Timing: the request is taken into the word and shift registers, then one
// shared shifter picks one byte per cycle into the output register while the
// output is not stalled; a request gives N output bytes (N = 0..4 at the
// default code length, up to 6 at 17). req_stall is high while the bytes
// of a request are being produced; a new request is taken while the final
// byte still waits in the output register.
module jpeg_bit_writer_with_stuffing_unit #(
   parameter int MAX_CODE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [jbws_pkg::OP_W-1:0]    req_op,
   input  logic [jbws_pkg::WORD_W-1:0]  req_value,
   input  logic [jbws_pkg::CNT_W-1:0]   req_bit_count,
   input  logic                         req_little_endian,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [jbws_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_last
);
   import jbws_pkg::*;

`include "jpeg_bit_writer_with_stuffing_unit_assert.svh"

   // Pending bits plus one saturated code.
   localparam int ACC_W = PEND_W + MAX_CODE_BITS;
   localparam logic [CNT_W-1:0] CODE_LIMIT = CNT_W'(MAX_CODE_BITS);
   localparam logic [SHIFT_W-1:0] BYTE_STEP = SHIFT_W'(BYTE_W);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [PEND_W-1:0]    pending_bits_ff, pending_bits_in;
   logic [PCNT_W-1:0]    pending_count_ff, pending_count_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic                 dir_up_ff, dir_up_in;      // byte order walk
   logic [REM_W-1:0]     remain_ff, remain_in;      // bytes left to pick
   logic                 stuff_en_ff, stuff_en_in;  // code-bit bytes only
   logic                 stuff_ff, stuff_in;        // 0x00 owed next
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 slot_free;
   logic [CNT_W-1:0]     n_bits;
   logic [WORD_W-1:0]    code_mask;
   logic [ACC_W-1:0]     acc;
   logic [CNT_W-1:0]     total;
   logic [PCNT_W-1:0]    rem_bits;
   logic [BYTE_W-1:0]    sel_byte;
   logic                 sel_is_ff;
   logic                 owe_stuff;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // Append path: merge the code below the pending bits.
   always_comb begin
      n_bits    = (req_bit_count > CODE_LIMIT) ? CODE_LIMIT : req_bit_count;
      code_mask = (WORD_W'(1) << n_bits) - WORD_W'(1);
      acc       = (ACC_W'(pending_bits_ff) << n_bits) | ACC_W'(req_value & code_mask);
      total     = CNT_W'(pending_count_ff) + n_bits;
      rem_bits  = total[PCNT_W-1:0];
   end

   // The one shifter that produces every output byte but the stuffing 0x00.
   jbws_byte_sel u_byte_sel (
      .word     (word_ff),
      .shift    (shift_ff),
      .byte_out (sel_byte),
      .is_ff    (sel_is_ff)
   );

   assign owe_stuff = stuff_en_ff && sel_is_ff;

   always_comb begin
      state_in         = state_ff;
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      word_in          = word_ff;
      shift_in         = shift_ff;
      dir_up_in        = dir_up_ff;
      remain_in        = remain_ff;
      stuff_en_in      = stuff_en_ff;
      stuff_in         = stuff_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_byte_in      = rsp_byte_ff;
      rsp_last_in      = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               stuff_en_in = 1'b0;
               stuff_in    = 1'b0;
               dir_up_in   = 1'b0;
               word_in     = req_value;
               shift_in    = '0;
               remain_in   = '0;
               case (op_type'(req_op))
                  OP_BITS: begin
                     word_in          = WORD_W'(acc);
                     shift_in         = SHIFT_W'(total) - BYTE_STEP;
                     remain_in        = REM_W'(total >> 3);
                     stuff_en_in      = 1'b1;
                     pending_bits_in  = acc[PEND_W-1:0] &
                                        ((PEND_W'(1) << rem_bits) - PEND_W'(1));
                     pending_count_in = rem_bits;
                  end
                  OP_BYTE: begin
                     remain_in = REM_W'(1);
                  end
                  OP_WORD16: begin
                     remain_in = REM_W'(2);
                     dir_up_in = req_little_endian;
                     shift_in  = req_little_endian ? '0 : BYTE_STEP;
                  end
                  OP_WORD32: begin
                     remain_in = REM_W'(4);
                     dir_up_in = req_little_endian;
                     shift_in  = req_little_endian ? '0 : SHIFT_W'(3 * BYTE_W);
                  end
                  OP_MARKER: begin
                     // prefix sits one byte above the code
                     word_in   = {{(WORD_W - 2 * BYTE_W){1'b0}}, MARKER_PREFIX,
                                  req_value[BYTE_W-1:0]};
                     remain_in = REM_W'(2);
                     shift_in  = BYTE_STEP;
                  end
                  default: begin
                     remain_in = '0;
                  end
               endcase
               if (remain_in != '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (stuff_ff) begin
                  rsp_byte_in = STUFF_BYTE;
                  rsp_last_in = (remain_ff == '0);
                  stuff_in    = 1'b0;
                  if (remain_ff == '0) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_byte_in = sel_byte;
                  rsp_last_in = (remain_ff == REM_W'(1)) && !owe_stuff;
                  stuff_in    = owe_stuff;
                  remain_in   = remain_ff - REM_W'(1);
                  shift_in    = dir_up_ff ? shift_ff + BYTE_STEP : shift_ff - BYTE_STEP;
                  if ((remain_ff == REM_W'(1)) && !owe_stuff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         remain_ff        <= '0;
         stuff_en_ff      <= 1'b0;
         stuff_ff         <= 1'b0;
         dir_up_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         remain_ff        <= remain_in;
         stuff_en_ff      <= stuff_en_in;
         stuff_ff         <= stuff_in;
         dir_up_ff        <= dir_up_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      word_ff     <= word_in;
      shift_ff    <= shift_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // An owed stuffing byte always follows a held, non-final 0xFF.
   `JBWS_ASSERT_NOW(a_stuff_after_ff, clock, reset, stuff_ff, rsp_valid_ff && (rsp_byte_ff == MARKER_PREFIX) && !rsp_last_ff, "stuff owed without a held 0xFF")
   // While busy there is always another byte to produce.
   `JBWS_ASSERT_NOW(a_busy_has_work, clock, reset, state_ff == ST_EMIT, (remain_ff != '0) || stuff_ff, "busy with nothing left")
   // The bit cache only moves when a request is taken.
   `JBWS_ASSERT_NEXT(a_cache_stable, clock, reset, state_ff == ST_EMIT, $stable(pending_count_ff) && $stable(pending_bits_ff), "bit cache moved while busy")

endmodule

// ===== sim/jbws_stream_checker.sv =====
`timescale 1ns / 1ps
module jbws_stream_checker #(
   parameter int MAX_CODE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [jbws_pkg::OP_W-1:0]    req_op,
   input  logic [jbws_pkg::WORD_W-1:0]  req_value,
   input  logic [jbws_pkg::CNT_W-1:0]   req_bit_count,
   input  logic                         req_little_endian,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [jbws_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                         rsp_last,
   output int                           fail_count,
   output int                           pending_results
);
   import jbws_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } stream_byte_t;

   stream_byte_t      expected_bytes[$];
   logic [PEND_W-1:0] cache_bits;
   logic [PCNT_W-1:0] cache_count;
   int                mismatches;

   assign fail_count = mismatches;

   initial begin
      mismatches      = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
   endtask

   // Bytes that one request adds to the stream; updates the bit cache.
   task automatic predict_stream_bytes(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] value,
                                       input logic [CNT_W-1:0] count,
                                       input logic low_first);
      stream_byte_t produced[$];
      logic [23:0]  acc;
      logic [7:0]   b;
      int           limit;
      int           n;
      int           total;
      int           nbytes;
      int           idx;
      limit = (MAX_CODE_BITS > 17) ? 17 : MAX_CODE_BITS;
      case (op)
         OP_BITS: begin
            n = (count > limit) ? limit : int'(count);
            if (n != 0) begin
               acc = (24'(cache_bits) << n) | 24'(value & ((32'd1 << n) - 32'd1));
               total = int'(cache_count) + n;
               while (total >= 8) begin
                  b = 8'(acc >> (total - 8));
                  produced.push_back('{data: b, last: 1'b0});
                  if (b == 8'hFF)
                     produced.push_back('{data: STUFF_BYTE, last: 1'b0});
                  total -= 8;
               end
               cache_bits  = PEND_W'(acc & ((24'd1 << total) - 24'd1));
               cache_count = PCNT_W'(total);
            end
         end
         OP_BYTE: produced.push_back('{data: value[7:0], last: 1'b0});
         OP_WORD16, OP_WORD32: begin
            nbytes = (op == OP_WORD16) ? 2 : 4;
            for (int i = 0; i < nbytes; i++) begin
               idx = low_first ? i : nbytes - 1 - i;
               produced.push_back('{data: 8'(value >> (8 * idx)), last: 1'b0});
            end
         end
         OP_MARKER: begin
            produced.push_back('{data: MARKER_PREFIX, last: 1'b0});
            produced.push_back('{data: value[7:0], last: 1'b0});
         end
         default: ;
      endcase
      if (produced.size() > 0)
         produced[produced.size() - 1].last = 1'b1;
      foreach (produced[i])
         expected_bytes.push_back(produced[i]);
   endtask

   always @(posedge clock) begin
      stream_byte_t want;
      if (reset) begin
         cache_bits  = '0;
         cache_count = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_out_byte, rsp_last));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want.data));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                            rsp_last, want.last, want.data));
            end
         end
         if (req_valid && !req_stall)
            predict_stream_bytes(req_op, req_value, req_bit_count, req_little_endian);
      end
      pending_results <= expected_bytes.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus side only: the checker watches both channels and keeps score.
module testbench;
   import jbws_pkg::*;

   localparam int CODE_BITS_MAX  = 16;
   localparam int RANDOM_ITEMS   = 400;
   localparam int IDLE_LIMIT     = 2000;  // cycles without any transaction
   localparam int DRAIN_CYCLES   = 16;    // extra wait after the stream drains
   localparam int PAUSE_INTERVAL = 130;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [WORD_W-1:0]   req_value;
   logic [CNT_W-1:0]    req_bit_count;
   logic                req_little_endian;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_last;

   int                  fail_count;
   int                  pending_results;
   int                  idle_cycles;
   bit                  calm;  // stretch with no idling on either side

   jpeg_bit_writer_with_stuffing_unit #(
      .MAX_CODE_BITS(CODE_BITS_MAX)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value         (req_value),
      .req_bit_count     (req_bit_count),
      .req_little_endian (req_little_endian),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last)
   );

   jbws_stream_checker #(
      .MAX_CODE_BITS(CODE_BITS_MAX)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value         (req_value),
      .req_bit_count     (req_bit_count),
      .req_little_endian (req_little_endian),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Values rich in ones, so 0xFF bytes and stuffing show up often.
   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return {16'($urandom_range(0, 65535)), 16'hFFFF};
         default: return $urandom;
      endcase
   endfunction

   // Holds one transaction until the block takes it. valid stays high across
   // back-to-back transactions, so only one NBA hits it per time step.
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [WORD_W-1:0] value,
                               input logic [CNT_W-1:0] count,
                               input logic low_first);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_value         <= value;
      req_bit_count     <= count;
      req_little_endian <= low_first;
      do @(posedge clock); while (req_stall);
   endtask

   // Sender drops valid and holds off until every byte predicted so far has
   // come out; the first edge lets the count take in the last transaction.
   task automatic wait_stream_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Output backpressure: runs of ready, broken up by stalls of random length.
   initial begin
      int run;
      int gap;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         run = $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      int next_pause;
      int r;
      logic [OP_W-1:0]   op;
      logic [CNT_W-1:0]  count;
      idle_cycles       = 0;
      calm              = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = OP_BITS;
      req_value         = '0;
      req_bit_count     = '0;
      req_little_endian = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      send_request(OP_BITS,   32'hFFFF_FFFF, 5'd0,  1'b0);  // zero count: no bytes
      send_request(OP_BITS,   32'h0000_FFFF, 5'd16, 1'b0);  // FF 00 FF 00
      send_request(OP_BITS,   32'h0000_0005, 5'd3,  1'b0);  // leaves 3 bits pending
      send_request(OP_BYTE,   32'hFFFF_FF5A, 5'd31, 1'b1);  // raw byte, excess bits
      send_request(OP_BITS,   32'hABCD_1234, 5'd16, 1'b0);  // excess value bits
      send_request(OP_BITS,   32'hFFFF_FFFF, 5'd31, 1'b0);  // count saturates
      send_request(OP_BITS,   32'h0000_0000, 5'd17, 1'b1);
      send_request(OP_WORD16, 32'h1234_ABCD, 5'd0,  1'b0);
      send_request(OP_WORD16, 32'h1234_ABCD, 5'd0,  1'b1);
      send_request(OP_WORD32, 32'h0123_4567, 5'd0,  1'b0);
      send_request(OP_WORD32, 32'h0123_4567, 5'd0,  1'b1);
      send_request(OP_WORD32, 32'hFFFF_FFFF, 5'd16, 1'b0);  // raw FF is not stuffed
      send_request(OP_MARKER, 32'h0000_00D9, 5'd0,  1'b0);
      send_request(OP_MARKER, 32'hFFFF_FFFF, 5'd0,  1'b1);  // marker, excess bits
      send_request(3'd5,      32'hFFFF_FFFF, 5'd16, 1'b0);  // unknown ops ignored
      send_request(3'd6,      32'h0000_0000, 5'd8,  1'b1);
      send_request(3'd7,      32'h5555_AAAA, 5'd31, 1'b0);
      send_request(OP_BITS,   32'h0000_001F, 5'd5,  1'b0);
      send_request(OP_BITS,   32'hFFFF_FFFF, 5'd8,  1'b0);  // FF from a single item
      send_request(OP_BITS,   32'h0000_0000, 5'd8,  1'b0);
      send_request(OP_BITS,   32'h0000_0001, 5'd1,  1'b0);
      send_request(OP_BITS,   32'h0000_0000, 5'd1,  1'b0);
      wait_stream_drained();

      // Random part: mostly code appends, raw writes and markers mixed in.
      counted    = 0;
      next_pause = PAUSE_INTERVAL;
      while (counted < RANDOM_ITEMS) begin
         calm = ((counted / 80) % 3) == 1;
         if (counted >= next_pause) begin
            wait_stream_drained();
            next_pause += PAUSE_INTERVAL;
         end
         r = $urandom_range(0, 99);
         count = CNT_W'($urandom_range(0, 31));
         if (r < 60) begin
            op    = OP_BITS;
            count = CNT_W'($urandom_range(1, 16));
         end else if (r < 67) op = OP_BYTE;
         else if (r < 74) op = OP_WORD16;
         else if (r < 81) op = OP_WORD32;
         else if (r < 88) op = OP_MARKER;
         else if (r < 93) begin
            op    = OP_BITS;
            count = CNT_W'($urandom_range(17, 31));
         end else if (r < 96) begin
            op    = OP_BITS;
            count = '0;
         end else op = OP_W'($urandom_range(5, 7));
         send_request(op, pick_value(), count, 1'($urandom_range(0, 1)));
         if (op <= OP_MARKER && !(op == OP_BITS && count == '0))
            counted++;
      end
      calm = 1'b0;

      wait_stream_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jbws_pkg.sv
rtl/jbws_byte_sel.sv
rtl/jpeg_bit_writer_with_stuffing_unit.sv
sim/jbws_stream_checker.sv
sim/testbench.sv
